// ===== rtl/dglr_pkg.sv =====
package dglr_pkg;

   // Default parameter values
   localparam int FRAC_BITS_DEF = 16;
   localparam int GRID_BITS_DEF = 10;

   // Fixed field widths
   localparam int ZOOM_W       = 6;
   localparam int ROW_OFFSET_W = 8;
   localparam int COLOR_W      = 24;
   localparam int HEIGHT_W     = 16;
   localparam int PIX_W        = 17;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 24;

   // Register reset values
   localparam logic [ZOOM_W-1:0]       ZOOM_RST         = 6'd30;
   localparam logic [ROW_OFFSET_W-1:0] ROW_OFFSET_RST   = 8'd18;
   localparam logic [COLOR_W-1:0]      FLAT_COLOR_RST   = 24'hffffff;
   localparam logic [COLOR_W-1:0]      RAISED_COLOR_RST = 24'hf00000;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ZOOM         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_OFFSET   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAT_COLOR   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAISED_COLOR = 2'd3;

   // Request function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

endpackage

// ===== rtl/dda_grid_line_rasterizer_unit.sv =====
// Start beat: ready drops while the scale, diff and length setup states run and while
// the divider forms the x step, then the y step; equal endpoints skip the divider.
// Tick beat: one per cycle; its pixel reaches the output register in the next cycle, and
// a tick is taken only while that register is empty or its pixel leaves that cycle.
// Reset (synchronous, active high) restores register defaults and leaves no line active.
module dda_grid_line_rasterizer_unit #(
   parameter int FRAC_BITS = dglr_pkg::FRAC_BITS_DEF,
   parameter int GRID_BITS = dglr_pkg::GRID_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write_en,
   input  logic [dglr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dglr_pkg::CSR_DATA_W-1:0]       csr_write_data,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_func,
   input  logic [GRID_BITS-1:0]                  req_start_col,
   input  logic [GRID_BITS-1:0]                  req_start_row,
   input  logic [GRID_BITS-1:0]                  req_end_col,
   input  logic [GRID_BITS-1:0]                  req_end_row,
   input  logic signed [dglr_pkg::HEIGHT_W-1:0]  req_start_height,
   input  logic signed [dglr_pkg::HEIGHT_W-1:0]  req_end_height,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dglr_pkg::PIX_W-1:0]            rsp_pixel_x,
   output logic [dglr_pkg::PIX_W-1:0]            rsp_pixel_y,
   output logic [dglr_pkg::COLOR_W-1:0]          rsp_pixel_color,
   output logic                                  rsp_last_pixel
);
   import dglr_pkg::*;

   localparam int ROW_W    = (GRID_BITS > ROW_OFFSET_W ? GRID_BITS : ROW_OFFSET_W) + 1;
   localparam int SCALED_W = ROW_W + ZOOM_W;
   localparam int SPAN_W   = SCALED_W > PIX_W ? SCALED_W : PIX_W;
   localparam int POS_W    = SPAN_W + FRAC_BITS;
   localparam int Q_W      = FRAC_BITS + 1;
   localparam int STEP_W   = Q_W + 1;
   localparam int CNT_W    = $clog2(FRAC_BITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIFF,
      ST_LEN,
      ST_DIV
   } state_type;

   state_type state_ff, state_in;

   logic [ZOOM_W-1:0]       zoom_ff, zoom_in;
   logic [ROW_OFFSET_W-1:0] row_offset_ff, row_offset_in;
   logic [COLOR_W-1:0]      flat_color_ff, flat_color_in;
   logic [COLOR_W-1:0]      raised_color_ff, raised_color_in;

   logic [GRID_BITS-1:0] col1_ff, col1_in, row1_ff, row1_in;
   logic [GRID_BITS-1:0] col2_ff, col2_in, row2_ff, row2_in;
   logic [COLOR_W-1:0]   line_color_ff, line_color_in;

   logic [SCALED_W-1:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic [SCALED_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic                neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;

   logic [POS_W-1:0]         pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [STEP_W-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [PIX_W-1:0]         pixels_left_ff, pixels_left_in;

   // shared divider
   logic [SCALED_W-1:0] div_len_ff, div_len_in;
   logic [SCALED_W:0]   div_rem_ff, div_rem_in;
   logic [Q_W-1:0]      div_quo_ff, div_quo_in;
   logic [CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic                div_y_ff, div_y_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    pixel_x_ff, pixel_x_in, pixel_y_ff, pixel_y_in;
   logic [COLOR_W-1:0]  pixel_color_ff, pixel_color_in;
   logic                last_pixel_ff, last_pixel_in;

   logic                accept;
   logic signed [SCALED_W:0] dx, dy;
   logic [SCALED_W-1:0] len;
   logic                div_ge;
   logic [SCALED_W:0]   div_diff;
   logic [Q_W-1:0]      div_quo_next;
   logic [STEP_W-1:0]   step_mag;
   logic [STEP_W-1:0]   step_val;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Line geometry from the scaled endpoints
   assign dx  = $signed({1'b0, x2_ff}) - $signed({1'b0, x1_ff});
   assign dy  = $signed({1'b0, y2_ff}) - $signed({1'b0, y1_ff});
   assign len = (ax_ff > ay_ff) ? ax_ff : ay_ff;

   // One restoring divide step: compare, subtract, shift
   assign div_ge       = div_rem_ff >= {1'b0, div_len_ff};
   assign div_diff     = div_ge ? (div_rem_ff - {1'b0, div_len_ff}) : div_rem_ff;
   assign div_quo_next = {div_quo_ff[Q_W-2:0], div_ge};
   assign step_mag     = {1'b0, div_quo_next};
   assign step_val     = (div_y_ff ? neg_y_ff : neg_x_ff) ? -step_mag : step_mag;

   always_comb begin
      state_in        = state_ff;
      zoom_in         = zoom_ff;
      row_offset_in   = row_offset_ff;
      flat_color_in   = flat_color_ff;
      raised_color_in = raised_color_ff;
      col1_in         = col1_ff;
      row1_in         = row1_ff;
      col2_in         = col2_ff;
      row2_in         = row2_ff;
      line_color_in   = line_color_ff;
      x1_in           = x1_ff;
      y1_in           = y1_ff;
      x2_in           = x2_ff;
      y2_in           = y2_ff;
      ax_in           = ax_ff;
      ay_in           = ay_ff;
      neg_x_in        = neg_x_ff;
      neg_y_in        = neg_y_ff;
      pos_x_in        = pos_x_ff;
      pos_y_in        = pos_y_ff;
      step_x_in       = step_x_ff;
      step_y_in       = step_y_ff;
      pixels_left_in  = pixels_left_ff;
      div_len_in      = div_len_ff;
      div_rem_in      = div_rem_ff;
      div_quo_in      = div_quo_ff;
      div_cnt_in      = div_cnt_ff;
      div_y_in        = div_y_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      pixel_x_in      = pixel_x_ff;
      pixel_y_in      = pixel_y_ff;
      pixel_color_in  = pixel_color_ff;
      last_pixel_in   = last_pixel_ff;

      // Configuration writes
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ZOOM:         zoom_in         = csr_write_data[ZOOM_W-1:0];
            CSR_ROW_OFFSET:   row_offset_in   = csr_write_data[ROW_OFFSET_W-1:0];
            CSR_FLAT_COLOR:   flat_color_in   = csr_write_data[COLOR_W-1:0];
            CSR_RAISED_COLOR: raised_color_in = csr_write_data[COLOR_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_START) begin
                  // latch the endpoints and pick the colour
                  col1_in       = req_start_col;
                  row1_in       = req_start_row;
                  col2_in       = req_end_col;
                  row2_in       = req_end_row;
                  line_color_in = (req_start_height == '0 && req_end_height == '0)
                                  ? flat_color_ff : raised_color_ff;
                  state_in      = ST_SCALE;
               end else if (pixels_left_ff != '0) begin
                  // emit one pixel and advance along the line
                  rsp_valid_in   = 1'b1;
                  pixel_x_in     = pos_x_ff[FRAC_BITS +: PIX_W];
                  pixel_y_in     = pos_y_ff[FRAC_BITS +: PIX_W];
                  pixel_color_in = line_color_ff;
                  last_pixel_in  = (pixels_left_ff == PIX_W'(1));
                  pos_x_in       = pos_x_ff + POS_W'(step_x_ff);
                  pos_y_in       = pos_y_ff + POS_W'(step_y_ff);
                  pixels_left_in = pixels_left_ff - PIX_W'(1);
               end
            end
         end
         ST_SCALE: begin
            // add the row offset and scale by zoom
            x1_in    = SCALED_W'(col1_ff) * SCALED_W'(zoom_ff);
            x2_in    = SCALED_W'(col2_ff) * SCALED_W'(zoom_ff);
            y1_in    = (SCALED_W'(row1_ff) + SCALED_W'(row_offset_ff)) * SCALED_W'(zoom_ff);
            y2_in    = (SCALED_W'(row2_ff) + SCALED_W'(row_offset_ff)) * SCALED_W'(zoom_ff);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // split the deltas into sign and magnitude, load the start position
            neg_x_in = dx[SCALED_W];
            neg_y_in = dy[SCALED_W];
            ax_in    = dx[SCALED_W] ? SCALED_W'(-dx) : dx[SCALED_W-1:0];
            ay_in    = dy[SCALED_W] ? SCALED_W'(-dy) : dy[SCALED_W-1:0];
            pos_x_in = POS_W'(x1_ff) << FRAC_BITS;
            pos_y_in = POS_W'(y1_ff) << FRAC_BITS;
            state_in = ST_LEN;
         end
         ST_LEN: begin
            pixels_left_in = PIX_W'(len);
            div_len_in     = len;
            if (len == '0) begin
               // degenerate line: no steps, nothing to draw
               step_x_in = '0;
               step_y_in = '0;
               state_in  = ST_IDLE;
            end else begin
               div_rem_in = {1'b0, ax_ff};
               div_quo_in = '0;
               div_cnt_in = CNT_W'(FRAC_BITS);
               div_y_in   = 1'b0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            div_rem_in = {div_diff[SCALED_W-1:0], 1'b0};
            div_quo_in = div_quo_next;
            div_cnt_in = div_cnt_ff - CNT_W'(1);
            if (div_cnt_ff == '0) begin
               if (!div_y_ff) begin
                  // x step done; restart the unit on the y delta
                  step_x_in  = $signed(step_val);
                  div_rem_in = {1'b0, ay_ff};
                  div_quo_in = '0;
                  div_cnt_in = CNT_W'(FRAC_BITS);
                  div_y_in   = 1'b1;
               end else begin
                  step_y_in = $signed(step_val);
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         zoom_ff         <= ZOOM_RST;
         row_offset_ff   <= ROW_OFFSET_RST;
         flat_color_ff   <= FLAT_COLOR_RST;
         raised_color_ff <= RAISED_COLOR_RST;
         pixels_left_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         zoom_ff         <= zoom_in;
         row_offset_ff   <= row_offset_in;
         flat_color_ff   <= flat_color_in;
         raised_color_ff <= raised_color_in;
         pixels_left_ff  <= pixels_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      col1_ff        <= col1_in;
      row1_ff        <= row1_in;
      col2_ff        <= col2_in;
      row2_ff        <= row2_in;
      line_color_ff  <= line_color_in;
      x1_ff          <= x1_in;
      y1_ff          <= y1_in;
      x2_ff          <= x2_in;
      y2_ff          <= y2_in;
      ax_ff          <= ax_in;
      ay_ff          <= ay_in;
      neg_x_ff       <= neg_x_in;
      neg_y_ff       <= neg_y_in;
      pos_x_ff       <= pos_x_in;
      pos_y_ff       <= pos_y_in;
      step_x_ff      <= step_x_in;
      step_y_ff      <= step_y_in;
      div_len_ff     <= div_len_in;
      div_rem_ff     <= div_rem_in;
      div_quo_ff     <= div_quo_in;
      div_cnt_ff     <= div_cnt_in;
      div_y_ff       <= div_y_in;
      pixel_x_ff     <= pixel_x_in;
      pixel_y_ff     <= pixel_y_in;
      pixel_color_ff <= pixel_color_in;
      last_pixel_ff  <= last_pixel_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = pixel_x_ff;
   assign rsp_pixel_y     = pixel_y_ff;
   assign rsp_pixel_color = pixel_color_ff;
   assign rsp_last_pixel  = last_pixel_ff;

endmodule

// ===== tb/tb_dda_grid_line_rasterizer_unit.sv =====
module tb_dda_grid_line_rasterizer_unit;
   import dglr_pkg::*;

   localparam int FRAC_W      = FRAC_BITS_DEF;
   localparam int GRID_W      = GRID_BITS_DEF;
   localparam int POS_W       = PIX_W + FRAC_W;
   localparam int STEP_W      = POS_W + 1;
   localparam int QUIET_WAIT  = 60;
   localparam int LONG_HOLD   = 160;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic                       func;
      logic [GRID_W-1:0]          start_col;
      logic [GRID_W-1:0]          start_row;
      logic [GRID_W-1:0]          end_col;
      logic [GRID_W-1:0]          end_row;
      logic signed [HEIGHT_W-1:0] start_height;
      logic signed [HEIGHT_W-1:0] end_height;
   } grid_beat_type;

   typedef struct packed {
      logic [PIX_W-1:0]   x;
      logic [PIX_W-1:0]   y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_func = 1'b0;
   logic [GRID_W-1:0]          req_start_col = '0;
   logic [GRID_W-1:0]          req_start_row = '0;
   logic [GRID_W-1:0]          req_end_col = '0;
   logic [GRID_W-1:0]          req_end_row = '0;
   logic signed [HEIGHT_W-1:0] req_start_height = '0;
   logic signed [HEIGHT_W-1:0] req_end_height = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [PIX_W-1:0]           rsp_pixel_x;
   logic [PIX_W-1:0]           rsp_pixel_y;
   logic [COLOR_W-1:0]         rsp_pixel_color;
   logic                       rsp_last_pixel;

   // Register copies as the block should hold them
   logic [ZOOM_W-1:0]       cfg_zoom = ZOOM_RST;
   logic [ROW_OFFSET_W-1:0] cfg_row_offset = ROW_OFFSET_RST;
   logic [COLOR_W-1:0]      cfg_flat_color = FLAT_COLOR_RST;
   logic [COLOR_W-1:0]      cfg_raised_color = RAISED_COLOR_RST;

   // Line walk state
   logic [POS_W-1:0]         walk_x = '0;
   logic [POS_W-1:0]         walk_y = '0;
   logic signed [STEP_W-1:0] stride_x = '0;
   logic signed [STEP_W-1:0] stride_y = '0;
   logic [PIX_W-1:0]         pixels_to_go = '0;
   logic [COLOR_W-1:0]       walk_color = '0;

   grid_beat_type request_backlog[$];
   pixel_type     pending_pixels[$];

   grid_beat_type offered_beat;
   pixel_type     predicted_pixel;
   pixel_type     wanted_pixel;
   bit         pixel_due;
   bit         offer_free;
   bit         sender_calm = 1'b0;
   bit         receiver_calm = 1'b0;
   int         gap_left = 0;
   int         stall_left = 0;
   int         hold_left = 0;
   int         beats_accepted = 0;
   int         pixels_checked = 0;
   int         settings_applied = 0;
   int         failures = 0;
   int         cycle_count = 0;

   dda_grid_line_rasterizer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_start_col    (req_start_col),
      .req_start_row    (req_start_row),
      .req_end_col      (req_end_col),
      .req_end_row      (req_end_row),
      .req_start_height (req_start_height),
      .req_end_height   (req_end_height),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Count failures, print only the first few
   function automatic void note_failure(input string what);
      failures++;
      if (failures <= 10) begin
         $display("%0d: %s", cycle_count, what);
      end
   endfunction

   // Signed fixed-point step: |d| << FRAC_W over the span, truncated, sign of d
   function automatic longint step_fraction(input int d, input int span);
      longint mag;
      longint quot;
      mag  = (d < 0) ? longint'(-d) : longint'(d);
      quot = (mag << FRAC_W) / longint'(span);
      return (d < 0) ? -quot : quot;
   endfunction

   // Advance the line walk by one accepted beat; flag a pixel when one is due
   function automatic void rasterize_beat(input grid_beat_type b, output bit emits,
                                          output pixel_type px);
      int x1;
      int y1;
      int x2;
      int y2;
      int dx;
      int dy;
      int ax;
      int ay;
      int span;
      emits = 1'b0;
      px    = '0;
      if (b.func == FUNC_START) begin
         x1   = int'(b.start_col) * int'(cfg_zoom);
         y1   = (int'(b.start_row) + int'(cfg_row_offset)) * int'(cfg_zoom);
         x2   = int'(b.end_col) * int'(cfg_zoom);
         y2   = (int'(b.end_row) + int'(cfg_row_offset)) * int'(cfg_zoom);
         dx   = x2 - x1;
         dy   = y2 - y1;
         ax   = (dx < 0) ? -dx : dx;
         ay   = (dy < 0) ? -dy : dy;
         span = (ax > ay) ? ax : ay;
         walk_color = (b.start_height == '0 && b.end_height == '0) ?
                      cfg_flat_color : cfg_raised_color;
         walk_x = POS_W'(longint'(x1) << FRAC_W);
         walk_y = POS_W'(longint'(y1) << FRAC_W);
         if (span == 0) begin
            stride_x = '0;
            stride_y = '0;
         end else begin
            stride_x = STEP_W'(step_fraction(dx, span));
            stride_y = STEP_W'(step_fraction(dy, span));
         end
         pixels_to_go = PIX_W'(span);
      end else if (pixels_to_go != '0) begin
         emits    = 1'b1;
         px.x     = walk_x[FRAC_W +: PIX_W];
         px.y     = walk_y[FRAC_W +: PIX_W];
         px.color = walk_color;
         px.last  = (pixels_to_go == PIX_W'(1));
         walk_x   = walk_x + stride_x[POS_W-1:0];
         walk_y   = walk_y + stride_y[POS_W-1:0];
         pixels_to_go = pixels_to_go - PIX_W'(1);
      end
   endfunction

   task automatic push_start(input int c0, input int r0, input int c1, input int r1,
                             input logic [HEIGHT_W-1:0] h0,
                             input logic [HEIGHT_W-1:0] h1);
      grid_beat_type b;
      b.func         = FUNC_START;
      b.start_col    = GRID_W'(c0);
      b.start_row    = GRID_W'(r0);
      b.end_col      = GRID_W'(c1);
      b.end_row      = GRID_W'(r1);
      b.start_height = h0;
      b.end_height   = h1;
      request_backlog.push_back(b);
   endtask

   // Ticks carry random filler in the unused fields
   task automatic push_ticks(input int count);
      grid_beat_type b;
      repeat (count) begin
         b.func         = FUNC_TICK;
         b.start_col    = GRID_W'($urandom);
         b.start_row    = GRID_W'($urandom);
         b.end_col      = GRID_W'($urandom);
         b.end_row      = GRID_W'($urandom);
         b.start_height = HEIGHT_W'($urandom);
         b.end_height   = HEIGHT_W'($urandom);
         request_backlog.push_back(b);
      end
   endtask

   // Mostly short lines walked to their end, with long and empty lines and noise
   task automatic queue_random_lines(input int budget);
      int counted;
      int kind;
      int reach;
      int c0;
      int r0;
      int c1;
      int r1;
      int delta;
      int span;
      int ticks;
      logic [HEIGHT_W-1:0] h0;
      logic [HEIGHT_W-1:0] h1;
      grid_beat_type noise;
      counted = 0;
      reach   = (int'(cfg_zoom) > 40) ? 1 : 40 / int'(cfg_zoom);
      while (counted < budget) begin
         kind = $urandom_range(0, 19);
         c0   = $urandom_range(0, 1023);
         r0   = $urandom_range(0, 1023);
         if ($urandom_range(0, 2) == 0) begin
            h0 = '0;
            h1 = '0;
         end else begin
            h0 = ($urandom_range(0, 3) == 0) ? '0 : HEIGHT_W'($urandom);
            h1 = ($urandom_range(0, 3) == 0) ? '0 : HEIGHT_W'($urandom);
         end
         if (kind == 0) begin
            noise.func         = 1'($urandom_range(0, 1));
            noise.start_col    = GRID_W'($urandom);
            noise.start_row    = GRID_W'($urandom);
            noise.end_col      = GRID_W'($urandom);
            noise.end_row      = GRID_W'($urandom);
            noise.start_height = HEIGHT_W'($urandom);
            noise.end_height   = HEIGHT_W'($urandom);
            request_backlog.push_back(noise);
            counted++;
         end else begin
            if (kind == 1) begin
               c1 = c0;
               r1 = r0;
            end else if (kind == 2) begin
               c1 = $urandom_range(0, 1023);
               r1 = $urandom_range(0, 1023);
            end else begin
               delta = int'($urandom_range(0, 2 * reach)) - reach;
               c1    = c0 + delta;
               if (c1 < 0 || c1 > 1023) c1 = c0 - delta;
               delta = int'($urandom_range(0, 2 * reach)) - reach;
               r1    = r0 + delta;
               if (r1 < 0 || r1 > 1023) r1 = r0 - delta;
            end
            span = (c1 > c0) ? c1 - c0 : c0 - c1;
            if (((r1 > r0) ? r1 - r0 : r0 - r1) > span) begin
               span = (r1 > r0) ? r1 - r0 : r0 - r1;
            end
            span = span * int'(cfg_zoom);
            // Cut some lines short so the next start replaces them
            if (kind == 2 || $urandom_range(0, 5) == 0) begin
               ticks = $urandom_range(0, (span < 6) ? span : 6);
            end else begin
               ticks = span + int'($urandom_range(0, 2));
            end
            push_start(c0, r0, c1, r1, h0, h1);
            push_ticks(ticks);
            counted += 1 + ((ticks < span) ? ticks : span);
         end
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_ZOOM:         cfg_zoom = data[ZOOM_W-1:0];
         CSR_ROW_OFFSET:   cfg_row_offset = data[ROW_OFFSET_W-1:0];
         CSR_FLAT_COLOR:   cfg_flat_color = data[COLOR_W-1:0];
         CSR_RAISED_COLOR: cfg_raised_color = data[COLOR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_registers(input logic [ZOOM_W-1:0] zoom,
                                    input logic [ROW_OFFSET_W-1:0] row_off,
                                    input logic [COLOR_W-1:0] flat,
                                    input logic [COLOR_W-1:0] raised);
      write_register(CSR_ZOOM, CSR_DATA_W'(zoom));
      write_register(CSR_ROW_OFFSET, CSR_DATA_W'(row_off));
      write_register(CSR_FLAT_COLOR, flat);
      write_register(CSR_RAISED_COLOR, raised);
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_applied++;
   endtask

   // Hold until every beat is taken and every pixel is back, then let the divider settle
   task automatic wait_for_quiet();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || pending_pixels.size() != 0);
      repeat (QUIET_WAIT) @(negedge clock);
   endtask

   // Request driver: offer the next beat, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         offer_free = !req_valid;
         if (req_valid && req_ready) begin
            rasterize_beat(offered_beat, pixel_due, predicted_pixel);
            if (pixel_due) pending_pixels.push_back(predicted_pixel);
            beats_accepted++;
            offer_free = 1'b1;
         end
         if (offer_free) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               offered_beat = request_backlog.pop_front();
               req_valid        <= 1'b1;
               req_func         <= offered_beat.func;
               req_start_col    <= offered_beat.start_col;
               req_start_row    <= offered_beat.start_row;
               req_end_col      <= offered_beat.end_col;
               req_end_row      <= offered_beat.end_row;
               req_start_height <= offered_beat.start_height;
               req_end_height   <= offered_beat.end_height;
               if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
               gap_left = sender_calm ? 0 : int'($urandom_range(0, 3));
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Pixel monitor: check each beat against the oldest prediction, then stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            pixels_checked++;
            if (pending_pixels.size() == 0) begin
               note_failure($sformatf("pixel (%0d,%0d) colour %h last %b with none outstanding",
                                      rsp_pixel_x, rsp_pixel_y, rsp_pixel_color,
                                      rsp_last_pixel));
            end else begin
               wanted_pixel = pending_pixels.pop_front();
               if (rsp_pixel_x !== wanted_pixel.x || rsp_pixel_y !== wanted_pixel.y ||
                   rsp_pixel_color !== wanted_pixel.color ||
                   rsp_last_pixel !== wanted_pixel.last) begin
                  note_failure($sformatf(
                     "pixel mismatch: expected (%0d,%0d) %h last %b, got (%0d,%0d) %h last %b",
                     wanted_pixel.x, wanted_pixel.y, wanted_pixel.color, wanted_pixel.last,
                     rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel));
               end
            end
            // Long hold-off lets the sender back up into the block
            if (pixels_checked == 120 || pixels_checked == 360) begin
               hold_left = LONG_HOLD;
            end else begin
               if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
               stall_left = receiver_calm ? 0 : int'($urandom_range(0, 3));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_dda_grid_line_rasterizer_unit: errors");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed lines at unit zoom
      program_registers(6'd1, ROW_OFFSET_RST, FLAT_COLOR_RST, RAISED_COLOR_RST);
      push_ticks(1);                                          // tick with no line
      push_start(5, 5, 5, 5, 16'sd7, 16'sd0);                 // equal endpoints
      push_ticks(1);
      push_start(0, 0, 3, 1, 16'sd0, 16'sd0);                 // flat, fractional y step
      push_ticks(4);                                          // one past the last pixel
      push_start(1023, 1023, 1020, 1023, -16'sd32768, 16'sd0); // leftward, cut short
      push_ticks(2);
      push_start(0, 1023, 1, 0, 16'sd32767, -16'sd1);         // steep upward, replaced
      push_ticks(2);
      push_start(2, 2, 0, 4, 16'sd0, 16'sd1);                 // diagonal, negative x
      push_ticks(2);
      wait_for_quiet();

      // Zero zoom collapses every line
      program_registers(6'd0, ROW_OFFSET_RST, FLAT_COLOR_RST, RAISED_COLOR_RST);
      push_start(0, 0, 1023, 1023, 16'sd1, 16'sd1);
      push_ticks(1);
      wait_for_quiet();

      // Random lines over a spread of register settings
      program_registers(ZOOM_RST, ROW_OFFSET_RST, FLAT_COLOR_RST, RAISED_COLOR_RST);
      queue_random_lines(88);
      wait_for_quiet();
      program_registers(6'd1, 8'd0, 24'h000000, 24'hffffff);
      queue_random_lines(88);
      wait_for_quiet();
      program_registers(6'd63, 8'd255, 24'hffffff, 24'h000000);
      queue_random_lines(88);
      wait_for_quiet();
      repeat (2) begin
         program_registers(ZOOM_W'($urandom_range(1, 63)), ROW_OFFSET_W'($urandom),
                           COLOR_W'($urandom), COLOR_W'($urandom));
         queue_random_lines(88);
         wait_for_quiet();
      end
      program_registers(6'd1, 8'd255, COLOR_W'($urandom), COLOR_W'($urandom));
      queue_random_lines(88);
      wait_for_quiet();

      if (pending_pixels.size() != 0) begin
         note_failure($sformatf("%0d predicted pixels never arrived", pending_pixels.size()));
      end
      $display("Covered %0d request beats and %0d pixels under %0d register settings,",
               beats_accepted, pixels_checked, settings_applied);
      $display("with two %0d-cycle output hold-offs; %0d failures", LONG_HOLD, failures);
      if (failures == 0) begin
         $display("tb_dda_grid_line_rasterizer_unit: clean");
      end else begin
         $display("tb_dda_grid_line_rasterizer_unit: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/dglr_pkg.sv
rtl/dda_grid_line_rasterizer_unit.sv
tb/tb_dda_grid_line_rasterizer_unit.sv
